// ===== design/rds_pkg.sv =====
// Shared types, constants and helpers for the reaction-diffusion rate unit.
`default_nettype none
package rds_pkg;

   // Grid and number format
   localparam int GRID_SIZE = 128;
   localparam int FRAC_BITS = 24;
   localparam int COORD_W   = 7;
   localparam int ADDR_W    = 14;
   localparam int CELLS     = GRID_SIZE * GRID_SIZE;
   localparam int DATA_W    = 32;
   localparam int RATE_W    = 31;
   localparam int WIDE_W    = 60;
   localparam int STEN_W    = 40;
   localparam int LIMB_W    = 32;
   localparam int PROD_W    = 4 * LIMB_W;
   localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
   localparam int DEN_W     = 58;
   localparam int FETCHES   = 9;
   localparam int STEPS     = 11;

   localparam logic [WIDE_W-1:0] WIDE_LIMIT = WIDE_W'(1) << 56;

   // Opcodes, status codes, register indexes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_SAT  = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;

   localparam logic [2:0] REG_CARRY   = 3'd0;
   localparam logic [2:0] REG_SATUR   = 3'd1;
   localparam logic [2:0] REG_SCALE   = 3'd2;
   localparam logic [2:0] REG_INV     = 3'd3;
   localparam logic [2:0] REG_GROWTH  = 3'd4;
   localparam logic [2:0] REG_DIFFUSE = 3'd5;
   localparam logic [2:0] REG_LAPLACE = 3'd6;

   typedef struct packed {
      logic                     opcode;
      logic [COORD_W-1:0]       row;
      logic [COORD_W-1:0]       col;
      logic signed [DATA_W-1:0] prey_value;
      logic signed [DATA_W-1:0] predator_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prey_rate;
      logic signed [DATA_W-1:0] predator_rate;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_CALC,
      S_WAIT,
      S_OUT
   } state_type;

   // Order of the fixed point operations of one evaluation
   typedef enum logic [3:0] {
      P_LAPU,
      P_LAPV,
      P_SU,
      P_T1,
      P_LOG,
      P_DIV,
      P_T2,
      P_PT,
      P_A,
      P_B,
      P_VV
   } step_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [WIDE_W-1:0] result;
   } mul_out_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_out_type;

   // Periodic coordinate step: c + d - 2 modulo the grid size
   function automatic logic [COORD_W-1:0] wrap_coord(logic [COORD_W-1:0] c, logic [2:0] d);
      logic [COORD_W+1:0] s;
      s = (COORD_W+2)'(c) + (COORD_W+2)'(GRID_SIZE) + (COORD_W+2)'(d) - (COORD_W+2)'(2);
      return COORD_W'(s % GRID_SIZE);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c);
   endfunction

   // Stencil read order: center, four along rows, four along columns
   function automatic logic [ADDR_W-1:0] fetch_addr(logic [COORD_W-1:0] r,
                                                    logic [COORD_W-1:0] c,
                                                    logic [3:0] k);
      logic [2:0] d;
      case (k)
         4'd1, 4'd5: d = 3'd0;
         4'd2, 4'd6: d = 3'd1;
         4'd3, 4'd7: d = 3'd3;
         4'd4, 4'd8: d = 3'd4;
         default:    d = 3'd2;
      endcase
      if (k >= 4'd1 && k <= 4'd4) begin
         return cell_addr(wrap_coord(r, d), c);
      end
      return cell_addr(r, wrap_coord(c, d));
   endfunction

   // Weighted stencil tap: -60 at center (both axes), 16 one away, -1 two away
   function automatic logic signed [STEN_W-1:0] sten_term(logic signed [DATA_W-1:0] t,
                                                         logic [3:0] k);
      logic signed [STEN_W-1:0] te;
      te = STEN_W'(t);
      case (k)
         4'd0:                      return (te <<< 2) - (te <<< 6);
         4'd2, 4'd3, 4'd6, 4'd7:    return te <<< 4;
         default:                   return -te;
      endcase
   endfunction

   function automatic logic [WIDE_W-1:0] wide_mag(logic signed [WIDE_W-1:0] a);
      return a[WIDE_W-1] ? WIDE_W'(-a) : WIDE_W'(a);
   endfunction

   function automatic logic sat32_over(logic signed [WIDE_W-1:0] v);
      return (v > WIDE_W'(32'sh7fffffff)) || (v < WIDE_W'(-64'sh80000000));
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(logic signed [WIDE_W-1:0] v);
      if (v > WIDE_W'(32'sh7fffffff)) begin
         return 32'sh7fffffff;
      end
      if (v < WIDE_W'(-64'sh80000000)) begin
         return -32'sh80000000;
      end
      return DATA_W'(v);
   endfunction

endpackage
`default_nettype wire

// ===== design/rds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/rds_fmul.sv =====
// Fixed point multiplier: four 32x32 partial products, truncate and clamp.
`default_nettype none
module rds_fmul
   import rds_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [WIDE_W-1:0] op_a,
   input  wire logic signed [WIDE_W-1:0] op_b,
   output mul_out_type                   mul_out
);
   logic [2*LIMB_W-1:0]      ua_ff, ub_ff;
   logic                     neg_ff;
   logic                     run_ff;
   logic [2:0]               cnt_ff;
   logic [2*LIMB_W-1:0]      pp_ff;
   logic [1:0]               sh_ff;
   logic [PROD_W-1:0]        acc_ff;
   logic                     done_ff;
   logic                     sat_ff;
   logic signed [WIDE_W-1:0] result_ff;

   logic [LIMB_W-1:0]           la, lb;
   logic [PROD_W-1:0]           pp_shift;
   logic [PROD_W-FRAC_BITS-1:0] trunc;
   logic                        over;
   logic [WIDE_W-1:0]           mres;

   // Pick limbs, align the partial product, truncate and clamp
   always_comb begin
      la    = cnt_ff[1] ? ua_ff[2*LIMB_W-1:LIMB_W] : ua_ff[LIMB_W-1:0];
      lb    = cnt_ff[0] ? ub_ff[2*LIMB_W-1:LIMB_W] : ub_ff[LIMB_W-1:0];
      pp_shift = PROD_W'(pp_ff) << (LIMB_W * sh_ff);
      trunc = acc_ff[PROD_W-1:FRAC_BITS];
      over  = trunc > (PROD_W-FRAC_BITS)'(WIDE_LIMIT);
      mres  = over ? WIDE_LIMIT : trunc[WIDE_W-1:0];
   end

   // Sequence: products on counts 0..3, accumulate on 1..4, finish on 5
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= (2*LIMB_W)'(wide_mag(op_a));
         ub_ff  <= (2*LIMB_W)'(wide_mag(op_b));
         neg_ff <= op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
         acc_ff <= '0;
      end else if (run_ff) begin
         if (cnt_ff <= 3'd3) begin
            pp_ff <= la * lb;
            sh_ff <= 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_ff <= acc_ff + pp_shift;
         end
         if (cnt_ff == 3'd5) begin
            sat_ff    <= over;
            result_ff <= neg_ff ? -$signed(mres) : $signed(mres);
         end
      end
   end

   assign mul_out.done   = done_ff;
   assign mul_out.sat    = sat_ff;
   assign mul_out.result = result_ff;
endmodule
`default_nettype wire

// ===== design/rds_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rds_div
   import rds_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output div_out_type           div_out
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   logic [DEN_W:0] trial;
   logic           fits;

   // Shift in the next dividend bit and trial subtract
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = trial >= (DEN_W+1)'(den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? DEN_W'(trial - (DEN_W+1)'(den_ff)) : DEN_W'(trial);
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign div_out.done = done_ff;
   assign div_out.quot = quo_ff;
endmodule
`default_nettype wire

// ===== design/reaction_diffusion_stencil_rate_unit.sv =====
// Reaction-diffusion rate unit: cell store, stencil fetch and rate sequencer.
//
// A load item (opcode 0) writes one cell in the cycle it is accepted and leaves
// busy low. An evaluate item (opcode 1) raises busy for nine stencil reads
// from the two grid RAMs, ten fixed point products on one iterative 32x32
// multiplier (each: issue, multiplier run, handoff), a bit-serial divide for
// the saturation ratio (57 quotient bits plus issue and handoff), and a result
// cycle. A zero divisor ends it early.
// The result appears on rsp_data for exactly one cycle with rsp_valid high and
// cannot be held off; busy is already low in that cycle. Write configuration
// registers only while busy is low and no result is pending.
`default_nettype none
module reaction_diffusion_stencil_rate_unit
   import rds_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [DATA_W-1:0] csr_wdata
);
   // Configuration registers
   logic signed [DATA_W-1:0] carry_ff, satur_ff, scale_ff, inv_ff;
   logic [RATE_W-1:0]        growth_ff, diffuse_ff, laplace_ff;

   // Control and datapath registers
   state_type                state_ff, state_in;
   step_type                 step_ff;
   logic [3:0]               fetch_cnt_ff;
   logic [COORD_W-1:0]       row_ff, col_ff;
   logic signed [STEN_W-1:0] sum_u_ff, sum_v_ff;
   logic signed [DATA_W-1:0] u_ff, v_ff;
   logic signed [WIDE_W-1:0] res_ff [STEPS];
   logic                     sat_ff, zero_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic                     accept, load;
   logic [COORD_W-1:0]       req_row, req_col;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        prey_rd, pred_rd;
   logic                     mul_start, div_start;
   logic signed [WIDE_W-1:0] op_a, op_b;
   mul_out_type              mul_out;
   div_out_type              div_out;
   logic signed [WIDE_W-1:0] den, nump_w;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     den_zero;
   logic                     q_over;
   logic [WIDE_W-1:0]        q_clamp;
   logic signed [WIDE_W-1:0] ratio;
   logic signed [WIDE_W-1:0] prey_sum, pred_sum;
   logic                     unit_done;

   assign accept  = start && !busy;
   assign load    = accept && (req_data.opcode == OP_LOAD);
   assign req_row = COORD_W'(req_data.row % GRID_SIZE);
   assign req_col = COORD_W'(req_data.col % GRID_SIZE);
   assign busy    = (state_ff != S_IDLE);

   // Grid stores
   rds_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_prey_ram (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (cell_addr(req_row, req_col)),
      .wr_data (req_data.prey_value),
      .rd_addr (rd_addr),
      .rd_data (prey_rd)
   );

   rds_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_pred_ram (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (cell_addr(req_row, req_col)),
      .wr_data (req_data.predator_value),
      .rd_addr (rd_addr),
      .rd_data (pred_rd)
   );

   // Shared arithmetic units
   rds_fmul u_fmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .mul_out (mul_out)
   );

   rds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .div_out  (div_out)
   );

   assign rd_addr = fetch_addr(row_ff, col_ff, fetch_cnt_ff);

   // Divider operands, zero check and quotient clamp
   always_comb begin
      den      = WIDE_W'(satur_ff) + res_ff[P_SU];
      nump_w   = WIDE_W'(satur_ff) + WIDE_W'(scale_ff);
      den_zero = (den == '0);
      div_num  = NUM_W'(wide_mag(nump_w)) << FRAC_BITS;
      div_den  = DEN_W'(wide_mag(den));
      q_over   = WIDE_W'(div_out.quot) > WIDE_LIMIT;
      q_clamp  = q_over ? WIDE_LIMIT : WIDE_W'(div_out.quot);
      ratio    = (nump_w[WIDE_W-1] ^ den[WIDE_W-1]) ? -$signed(q_clamp) : $signed(q_clamp);
      prey_sum = res_ff[P_A] + res_ff[P_B];
      pred_sum = res_ff[P_PT] - res_ff[P_VV] + res_ff[P_LAPV];
      unit_done = (step_ff == P_DIV) ? div_out.done : mul_out.done;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.opcode == OP_EVAL) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (fetch_cnt_ff == 4'(FETCHES)) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (step_ff == P_T1 && den_zero) begin
               state_in = S_OUT;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (unit_done) begin
               state_in = (step_ff == P_VV) ? S_OUT : S_CALC;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Unit starts and operand selection
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      op_a      = '0;
      op_b      = '0;
      if (state_ff == S_CALC && !(step_ff == P_T1 && den_zero)) begin
         div_start = (step_ff == P_DIV);
         mul_start = (step_ff != P_DIV);
      end
      unique case (step_ff)
         P_LAPU: begin
            op_a = WIDE_W'(sum_u_ff);
            op_b = WIDE_W'(laplace_ff);
         end
         P_LAPV: begin
            op_a = WIDE_W'(sum_v_ff);
            op_b = WIDE_W'(laplace_ff);
         end
         P_SU: begin
            op_a = WIDE_W'(scale_ff);
            op_b = WIDE_W'(u_ff);
         end
         P_T1: begin
            op_a = WIDE_W'(carry_ff) - res_ff[P_SU];
            op_b = WIDE_W'(inv_ff);
         end
         P_LOG: begin
            op_a = res_ff[P_T1];
            op_b = WIDE_W'(u_ff);
         end
         P_T2: begin
            op_a = res_ff[P_DIV];
            op_b = WIDE_W'(u_ff);
         end
         P_PT: begin
            op_a = res_ff[P_T2];
            op_b = WIDE_W'(v_ff);
         end
         P_A: begin
            op_a = WIDE_W'(growth_ff);
            op_b = res_ff[P_LOG] - res_ff[P_PT];
         end
         P_B: begin
            op_a = WIDE_W'(diffuse_ff);
            op_b = res_ff[P_LAPU];
         end
         P_VV: begin
            op_a = WIDE_W'(v_ff);
            op_b = WIDE_W'(v_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= P_LAPU;
         fetch_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_OUT);
         if (state_ff == S_IDLE) begin
            fetch_cnt_ff <= '0;
            step_ff      <= P_LAPU;
         end else if (state_ff == S_FETCH) begin
            fetch_cnt_ff <= fetch_cnt_ff + 4'd1;
         end else if (state_ff == S_WAIT && unit_done && step_ff != P_VV) begin
            step_ff <= step_type'(step_ff + 4'd1);
         end
      end
   end

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff   <= '0;
         satur_ff   <= '0;
         scale_ff   <= '0;
         inv_ff     <= '0;
         growth_ff  <= RATE_W'(55918461);
         diffuse_ff <= RATE_W'(5033165);
         laplace_ff <= RATE_W'(5536621);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CARRY:   carry_ff   <= csr_wdata;
            REG_SATUR:   satur_ff   <= csr_wdata;
            REG_SCALE:   scale_ff   <= csr_wdata;
            REG_INV:     inv_ff     <= csr_wdata;
            REG_GROWTH:  growth_ff  <= csr_wdata[RATE_W-1:0];
            REG_DIFFUSE: diffuse_ff <= csr_wdata[RATE_W-1:0];
            REG_LAPLACE: laplace_ff <= csr_wdata[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff   <= req_row;
         col_ff   <= req_col;
         sum_u_ff <= '0;
         sum_v_ff <= '0;
         sat_ff   <= 1'b0;
         zero_ff  <= 1'b0;
      end
      // Accumulate stencil taps one read behind the address
      if (state_ff == S_FETCH && fetch_cnt_ff != 4'd0) begin
         sum_u_ff <= sum_u_ff + sten_term(prey_rd, fetch_cnt_ff - 4'd1);
         sum_v_ff <= sum_v_ff + sten_term(pred_rd, fetch_cnt_ff - 4'd1);
         if (fetch_cnt_ff == 4'd1) begin
            u_ff <= prey_rd;
            v_ff <= pred_rd;
         end
      end
      if (state_ff == S_CALC && step_ff == P_T1 && den_zero) begin
         zero_ff <= 1'b1;
      end
      // Hold each unit result in its step slot
      if (state_ff == S_WAIT && unit_done) begin
         if (step_ff == P_DIV) begin
            res_ff[step_ff] <= ratio;
            sat_ff          <= sat_ff | q_over;
         end else begin
            res_ff[step_ff] <= mul_out.result;
            sat_ff          <= sat_ff | mul_out.sat;
         end
      end
      if (state_ff == S_OUT) begin
         if (zero_ff) begin
            rsp_ff.prey_rate     <= '0;
            rsp_ff.predator_rate <= '0;
            rsp_ff.status        <= STAT_ZERO;
         end else begin
            rsp_ff.prey_rate     <= sat32(prey_sum);
            rsp_ff.predator_rate <= sat32(pred_sum);
            rsp_ff.status        <= (sat_ff || sat32_over(prey_sum) || sat32_over(pred_sum))
                                    ? STAT_SAT : STAT_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result transfer only follows the result cycle of the sequencer
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_OUT)
      else $error("result strobe without result cycle");

   // Status is never the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STAT_OK || rsp_data.status == STAT_SAT ||
                     rsp_data.status == STAT_ZERO))
      else $error("bad status code");

   // Units finish only while the sequencer waits on them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      (mul_out.done || div_out.done) |-> state_ff == S_WAIT)
      else $error("unit finished outside wait");

   // After a unit starts, the block stays busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (mul_start || div_start) |=> busy)
      else $error("unit started while idle");
endmodule
`default_nettype wire
